@@ sv/lbgw_pkg.sv @@
`default_nettype none
package lbgw_pkg;

   localparam int FrameWidth  = 320;
   localparam int FrameHeight = 240;
   localparam int FrameDepth  = FrameWidth * FrameHeight;
   localparam int FrameAw     = $clog2(FrameDepth);
   localparam int ColW        = 9;
   localparam int RowW        = 8;
   localparam int RegDepth    = 256;
   localparam int RegAw       = 8;

   localparam logic [7:0] GramIndex  = 8'h22;
   localparam logic [7:0] EntryMode  = 8'h03;
   localparam logic [7:0] IdIndex    = 8'h00;
   localparam logic [7:0] DriverOut  = 8'h01;
   localparam logic [7:0] HAddrIndex = 8'h20;
   localparam logic [7:0] VAddrIndex = 8'h21;
   localparam logic [7:0] HStartIdx  = 8'h50;
   localparam logic [7:0] HEndIdx    = 8'h51;
   localparam logic [7:0] VStartIdx  = 8'h52;
   localparam logic [7:0] VEndIdx    = 8'h53;
   localparam logic [15:0] DeviceId  = 16'h9335;

   typedef enum logic [1:0] {
      ACT_CMD_WR = 2'd0,
      ACT_CMD_RD = 2'd1,
      ACT_DAT_WR = 2'd2,
      ACT_DAT_RD = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;  // write zero at clear address and advance
      logic exec;        // carry out the held request
      logic fetch;       // frame read issued last cycle, data now valid
      logic capture;     // latch response byte
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic needs_fetch; // gram read that reloads the shift register
      logic has_resp;
   } status_type;

   function automatic logic [15:0] write_mask(input logic [7:0] r);
      logic [15:0] m;
      begin
         unique case (r)
            8'h01: m = 16'h0500; 8'h03: m = 16'hD0B8; 8'h04: m = 16'h0777;
            8'h05: m = 16'h0003; 8'h06: m = 16'h0001; 8'h07: m = 16'h313B;
            8'h08: m = 16'hFFFF; 8'h09: m = 16'h073F; 8'h0A: m = 16'h000F;
            8'h0C: m = 16'h7133; 8'h0D: m = 16'h01FF; 8'h0F: m = 16'h001B;
            8'h10: m = 16'h17F3; 8'h11: m = 16'h0777; 8'h12: m = 16'h008F;
            8'h13: m = 16'h1F00; 8'h20: m = 16'h00FF; 8'h21: m = 16'h01FF;
            8'h29: m = 16'h003F; 8'h2B: m = 16'h000F; 8'h30: m = 16'h0707;
            8'h31: m = 16'h0707; 8'h32: m = 16'h0707; 8'h35: m = 16'h0707;
            8'h36: m = 16'h1F0F; 8'h37: m = 16'h0707; 8'h38: m = 16'h0707;
            8'h39: m = 16'h0707; 8'h3C: m = 16'h0707; 8'h3D: m = 16'h1F0F;
            8'h50: m = 16'h00FF; 8'h51: m = 16'h00FF; 8'h52: m = 16'h01FF;
            8'h53: m = 16'h01FF; 8'h60: m = 16'hBF3F; 8'h61: m = 16'h0007;
            8'h6A: m = 16'h01FF; 8'h80: m = 16'h01FF; 8'h81: m = 16'h01FF;
            8'h82: m = 16'h01FF; 8'h83: m = 16'h01FF; 8'h84: m = 16'h01FF;
            8'h85: m = 16'h01FF; 8'h90: m = 16'h031F; 8'h92: m = 16'h0700;
            8'h95: m = 16'h0300; 8'h97: m = 16'h0F00; 8'hA1: m = 16'h083F;
            8'hA2: m = 16'h0001; 8'hA3: m = 16'h0003; 8'hA4: m = 16'hF7FF;
            8'hA5: m = 16'hFFFF; 8'hE2: m = 16'h9FFF; 8'hE3: m = 16'hF0FF;
            8'hE4: m = 16'h1F3C; 8'hE5: m = 16'h1FC7; 8'hE6: m = 16'h0001;
            8'hE7: m = 16'h3FFF; 8'hE8: m = 16'h003F; 8'hE9: m = 16'h000F;
            8'hEA: m = 16'hFFFF; 8'hEB: m = 16'hB37F; 8'hEC: m = 16'h7FFF;
            8'hED: m = 16'h7FFF; 8'hEE: m = 16'h0F7F; 8'hEF: m = 16'hFB37;
            8'hFE: m = 16'h0001; 8'hFF: m = 16'h000F;
            default: m = 16'hFFFF;
         endcase
         return m;
      end
   endfunction

endpackage
`default_nettype wire

@@ sv/lbgw_ram.sv @@
`default_nettype none
module lbgw_ram #(
   parameter int Width = 18,
   parameter int Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ sv/lbgw_ctrl.sv @@
`default_nettype none
module lbgw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire lbgw_pkg::status_type status,
   output lbgw_pkg::cmd_type       cmd
);
   import lbgw_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec    = 1'b1;
            cmd.capture = status.has_resp;
            priority if (status.needs_fetch) begin
               state_in = ST_READ;
            end else if (status.has_resp) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.fetch = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

@@ sv/lbgw_dp.sv @@
`default_nettype none
module lbgw_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_take,
   input  wire logic [1:0]          req_action,
   input  wire logic [7:0]          req_data_byte,
   input  wire lbgw_pkg::cmd_type   cmd,
   output lbgw_pkg::status_type     status,
   output logic [7:0]               rsp_read_byte
);
   import lbgw_pkg::*;

   // held request
   action_type act_ff;
   logic [7:0] byte_ff;

   logic [7:0]  reg_index_ff, reg_index_in;
   // copies of the registers that steer the cursor and pixel path
   logic [15:0] mode_ff, mode_in;
   logic        flip_ff, flip_in;
   logic [RowW-1:0] h_addr_ff, h_addr_in;
   logic [ColW-1:0] v_addr_ff, v_addr_in;
   logic [15:0] h_start_ff, h_start_in;
   logic [15:0] h_end_ff, h_end_in;
   logic [15:0] v_start_ff, v_start_in;
   logic [15:0] v_end_ff, v_end_in;
   logic [23:0] byte_buffer_ff, byte_buffer_in;
   logic [1:0]  write_phase_ff, write_phase_in;
   logic        read_phase_ff, read_phase_in;
   logic [23:0] read_shift_ff, read_shift_in;
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [FrameAw-1:0] clr_addr_ff;
   logic [7:0]  rsp_ff;

   // frame memory ports
   logic               fm_we;
   logic [FrameAw-1:0] fm_waddr, fm_raddr;
   logic [17:0]        fm_wdata, fm_rdata;

   // register file ports
   logic               rf_we;
   logic [RegAw-1:0]   rf_waddr;
   logic [15:0]        rf_wdata, rf_rdata;

   lbgw_ram #(.Width(18), .Depth(FrameDepth)) u_frame (
      .clock   (clock),
      .wr_en   (fm_we),
      .wr_addr (fm_waddr),
      .wr_data (fm_wdata),
      .rd_addr (fm_raddr),
      .rd_data (fm_rdata)
   );

   // read address is the register index, stable since the idle cycle before execute
   lbgw_ram #(.Width(16), .Depth(RegDepth)) u_regs (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (reg_index_ff),
      .rd_data (rf_rdata)
   );

   logic [15:0] mode;
   assign mode = mode_ff;

   // pixel assembly and store
   logic [23:0] buf_new;
   logic        is_gram, mode18, do_pixel, do_reg;
   logic [1:0]  wp_inc;
   logic [5:0]  pr, pg, pb, s0, s2;
   logic [15:0] v16, reg_val;
   logic [23:0] v24;
   logic [ColW-1:0] ncol, col_wr, col_st;
   logic [RowW-1:0] nrow, row_wr, row_st;
   logic signed [RowW+1:0] frow;
   logic        in_frame;
   logic [15:0] r50, r51, r52, r53;
   logic        col_wrap, row_wrap;

   assign r50 = h_start_ff;
   assign r51 = h_end_ff;
   assign r52 = v_start_ff;
   assign r53 = v_end_ff;

   assign is_gram = (reg_index_ff == GramIndex);
   assign mode18  = mode[14];
   assign buf_new = {byte_buffer_ff[15:0], byte_ff};
   assign wp_inc  = write_phase_ff + 2'd1;
   assign v16     = buf_new[15:0];
   assign v24     = buf_new & 24'hfcfcfc;

   always_comb begin
      do_pixel = 1'b0;
      do_reg   = 1'b0;
      pr = '0; pg = '0; pb = '0;
      write_phase_in = write_phase_ff;
      if (is_gram && mode18) begin
         write_phase_in = wp_inc;
         if (write_phase_ff >= 2'd2) begin
            write_phase_in = 2'd0;
            do_pixel = 1'b1;
            if (mode[15]) begin
               pr = v24[23:18]; pg = v24[15:10]; pb = v24[7:2];
            end else begin
               pr = buf_new[17:12]; pg = buf_new[11:6]; pb = buf_new[5:0];
            end
         end
      end else begin
         write_phase_in = (write_phase_ff == 2'd0) ? 2'd1 : 2'd0;
         if (write_phase_ff != 2'd0) begin
            if (is_gram) begin
               do_pixel = 1'b1;
               pr = {v16[15:11], v16[15]};
               pg = v16[10:5];
               pb = {v16[4:0], v16[4]};
            end else begin
               do_reg = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (mode[12]) begin
         s0 = pb; s2 = pr;
      end else begin
         s0 = pr; s2 = pb;
      end
      frow = flip_ff
           ? $signed((RowW+2)'(FrameHeight - 1)) - $signed({2'b00, row_ff})
           : $signed({2'b00, row_ff});
      in_frame = (int'(col_ff) < FrameWidth) && (frow >= 0)
               && (frow < $signed((RowW+2)'(FrameHeight)));
   end

   // cursor advance with window wrap; column first when mode bit 3
   always_comb begin
      logic cstep_up, rstep_up;
      cstep_up = mode[5];
      rstep_up = mode[4];
      if (cstep_up) begin
         col_wrap = !(16'(col_ff) < r53);
         ncol = col_wrap ? r52[ColW-1:0] : col_ff + ColW'(1);
      end else begin
         col_wrap = !(16'(col_ff) > r52);
         ncol = col_wrap ? r53[ColW-1:0] : col_ff - ColW'(1);
      end
      if (rstep_up) begin
         row_wrap = !(16'(row_ff) < r51);
         nrow = row_wrap ? r50[RowW-1:0] : row_ff + RowW'(1);
      end else begin
         row_wrap = !(16'(row_ff) > r50);
         nrow = row_wrap ? r51[RowW-1:0] : row_ff - RowW'(1);
      end
      if (mode[3]) begin
         col_st = ncol;
         row_st = col_wrap ? nrow : row_ff;
      end else begin
         row_st = nrow;
         col_st = row_wrap ? ncol : col_ff;
      end
   end

   // register write and its cursor effects
   always_comb begin
      logic [15:0] nm;
      logic org;
      nm  = 16'h0;
      org = mode[7];
      reg_val = v16 & write_mask(reg_index_ff);
      col_wr = col_ff;
      row_wr = row_ff;
      unique case (reg_index_ff)
         EntryMode: begin
            nm = reg_val;
            col_wr = nm[5] ? r52[ColW-1:0] : r53[ColW-1:0];
            row_wr = nm[4] ? r50[RowW-1:0] : r51[RowW-1:0];
         end
         HAddrIndex: begin
            if (org) row_wr = mode[4] ? r50[RowW-1:0] : r51[RowW-1:0];
            else begin
               col_wr = v_addr_ff;
               row_wr = reg_val[RowW-1:0];
            end
         end
         VAddrIndex: begin
            if (org) col_wr = mode[5] ? r52[ColW-1:0] : r53[ColW-1:0];
            else begin
               col_wr = reg_val[ColW-1:0];
               row_wr = h_addr_ff;
            end
         end
         HStartIdx: if (org && mode[5])  row_wr = reg_val[RowW-1:0];
         HEndIdx:   if (org && !mode[5]) row_wr = reg_val[RowW-1:0];
         VStartIdx: if (org && mode[4])  col_wr = reg_val[ColW-1:0];
         VEndIdx:   if (org && !mode[4]) col_wr = reg_val[ColW-1:0];
         default: ;
      endcase
   end

   // gram read address: cursor modulo frame size
   logic [ColW-1:0] rcol;
   logic [RowW-1:0] rrow;
   always_comb begin
      rcol = (int'(col_ff) >= FrameWidth) ? ColW'(int'(col_ff) - FrameWidth) : col_ff;
      rrow = (int'(row_ff) >= FrameHeight) ? RowW'(int'(row_ff) - FrameHeight) : row_ff;
   end

   logic [FrameAw-1:0] row_base;
   always_comb begin
      row_base = FrameAw'(rrow) * FrameAw'(FrameWidth);
   end

   logic [15:0] reg_rd;
   assign reg_rd = (reg_index_ff == IdIndex) ? DeviceId : rf_rdata;

   // rgb565 from the frame word
   logic [23:0] p565, rgb565;
   always_comb begin
      logic [5:0] hi, lo;
      if (mode[12]) begin
         hi = fm_rdata[5:0]; lo = fm_rdata[17:12];
      end else begin
         hi = fm_rdata[17:12]; lo = fm_rdata[5:0];
      end
      p565 = {2'b00, hi, 2'b00, fm_rdata[11:6], 2'b00, lo};
      rgb565 = ((p565 & 24'h3e0000) << 2) | ((p565 & 24'h003f00) << 5)
             | ((p565 & 24'h00003e) << 7);
   end

   logic rp_next;
   assign rp_next = ~read_phase_ff;

   always_comb begin
      fm_we    = 1'b0;
      fm_waddr = clr_addr_ff;
      fm_wdata = '0;
      fm_raddr = row_base + FrameAw'(rcol);
      if (cmd.clear_step) begin
         fm_we = 1'b1;
      end else if (cmd.exec && act_ff == ACT_DAT_WR && do_pixel && in_frame) begin
         fm_we    = 1'b1;
         fm_waddr = FrameAw'(frow[RowW-1:0]) * FrameAw'(FrameWidth) + FrameAw'(col_ff);
         fm_wdata = {s0, pg, s2};
      end
   end

   // register file zeroed alongside the frame memory
   always_comb begin
      rf_we    = 1'b0;
      rf_waddr = clr_addr_ff[RegAw-1:0];
      rf_wdata = '0;
      if (cmd.clear_step) begin
         rf_we = 1'b1;
      end else if (cmd.exec && act_ff == ACT_DAT_WR && do_reg) begin
         rf_we    = 1'b1;
         rf_waddr = reg_index_ff;
         rf_wdata = reg_val;
      end
   end

   assign status.clear_done  = (int'(clr_addr_ff) == FrameDepth - 1);
   assign status.has_resp    = (act_ff == ACT_CMD_RD) || (act_ff == ACT_DAT_RD);
   assign status.needs_fetch = (act_ff == ACT_DAT_RD) && is_gram && !rp_next;

   always_comb begin
      reg_index_in   = reg_index_ff;
      mode_in        = mode_ff;
      flip_in        = flip_ff;
      h_addr_in      = h_addr_ff;
      v_addr_in      = v_addr_ff;
      h_start_in     = h_start_ff;
      h_end_in       = h_end_ff;
      v_start_in     = v_start_ff;
      v_end_in       = v_end_ff;
      byte_buffer_in = byte_buffer_ff;
      read_phase_in  = read_phase_ff;
      read_shift_in  = read_shift_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      if (cmd.fetch) begin
         read_shift_in = rgb565;
      end else if (cmd.exec) begin
         unique case (act_ff)
            ACT_CMD_WR: begin
               reg_index_in  = byte_ff;
               read_phase_in = 1'b0;
            end
            ACT_CMD_RD: ;
            ACT_DAT_WR: begin
               byte_buffer_in = buf_new;
               if (do_pixel) begin
                  col_in = col_st;
                  row_in = row_st;
               end else if (do_reg) begin
                  col_in = col_wr;
                  row_in = row_wr;
                  unique case (reg_index_ff)
                     EntryMode:  mode_in    = reg_val;
                     DriverOut:  flip_in    = reg_val[8];
                     HAddrIndex: h_addr_in  = reg_val[RowW-1:0];
                     VAddrIndex: v_addr_in  = reg_val[ColW-1:0];
                     HStartIdx:  h_start_in = reg_val;
                     HEndIdx:    h_end_in   = reg_val;
                     VStartIdx:  v_start_in = reg_val;
                     VEndIdx:    v_end_in   = reg_val;
                     default: ;
                  endcase
               end
            end
            ACT_DAT_RD: begin
               read_phase_in = rp_next;
               if (is_gram && rp_next) read_shift_in = {read_shift_ff[15:0], 8'h00};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_index_ff   <= '0;
         mode_ff        <= '0;
         flip_ff        <= 1'b0;
         h_addr_ff      <= '0;
         v_addr_ff      <= '0;
         h_start_ff     <= '0;
         h_end_ff       <= '0;
         v_start_ff     <= '0;
         v_end_ff       <= '0;
         byte_buffer_ff <= '0;
         write_phase_ff <= '0;
         read_phase_ff  <= 1'b0;
         read_shift_ff  <= '0;
         col_ff         <= ColW'(319);
         row_ff         <= RowW'(239);
         clr_addr_ff    <= '0;
      end else begin
         reg_index_ff   <= reg_index_in;
         mode_ff        <= mode_in;
         flip_ff        <= flip_in;
         h_addr_ff      <= h_addr_in;
         v_addr_ff      <= v_addr_in;
         h_start_ff     <= h_start_in;
         h_end_ff       <= h_end_in;
         v_start_ff     <= v_start_in;
         v_end_ff       <= v_end_in;
         byte_buffer_ff <= byte_buffer_in;
         read_phase_ff  <= read_phase_in;
         read_shift_ff  <= read_shift_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         if (cmd.exec && act_ff == ACT_CMD_WR) begin
            write_phase_ff <= '0;
         end else if (cmd.exec && act_ff == ACT_DAT_WR) begin
            write_phase_ff <= write_phase_in;
         end
         if (cmd.clear_step && !status.clear_done) begin
            clr_addr_ff <= clr_addr_ff + FrameAw'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff  <= action_type'(req_action);
         byte_ff <= req_data_byte;
      end
      if (cmd.capture) begin
         if (act_ff == ACT_CMD_RD) rsp_ff <= 8'h00;
         else if (is_gram) rsp_ff <= read_shift_ff[23:16];
         else rsp_ff <= rp_next ? reg_rd[15:8] : reg_rd[7:0];
      end
   end

   assign rsp_read_byte = rsp_ff;

endmodule
`default_nettype wire

@@ sv/lcd_bus_gram_window_writer_top.sv @@
`default_nettype none
// Byte-wide bus interface of an lcd controller with a 320x240 gram of 18-bit words.
// A write is accepted in the idle state and carried out in the execute state. A read
// then sits in the response state, its byte offered from an output register until
// taken, and a gram read that reloads the pixel shift register first passes the read
// state, since the frame memory read is registered. After reset the frame memory and
// the 256-entry register file are zeroed one word per cycle, with req_stall high.
module lcd_bus_gram_window_writer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_byte
);
   import lbgw_pkg::*;

   cmd_type    cmd;
   status_type status;

   lbgw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lbgw_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_take      (req_valid && !req_stall),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .cmd           (cmd),
      .status        (status),
      .rsp_read_byte (rsp_read_byte)
   );

endmodule
`default_nettype wire

@@ tb/lcd_bus_gram_window_writer_top_tb.sv @@
`default_nettype none
module lcd_bus_gram_window_writer_top_tb;
   import lbgw_pkg::*;

   // software copy of the controller: registers, cursor and frame memory
   class lcd_scoreboard;
      logic [7:0]  index;
      logic [15:0] regs [256];
      logic [23:0] bytes_in;
      logic [1:0]  wphase;
      logic        rphase;
      logic [23:0] rd_shift;
      logic [8:0]  col;
      logic [7:0]  row;
      logic [17:0] gram [FrameDepth];
      logic [7:0]  pending_bytes [$];
      int          errors;
      int          reads_seen;

      function void clear();
         index = '0; bytes_in = '0; wphase = '0; rphase = 1'b0; rd_shift = '0;
         col = 9'd319; row = 8'd239; errors = 0; reads_seen = 0;
         foreach (regs[i]) regs[i] = '0;
         foreach (gram[i]) gram[i] = '0;
      endfunction

      function logic [15:0] mask_of(logic [7:0] r);
         case (r)
            8'h01: return 16'h0500; 8'h03: return 16'hD0B8; 8'h04: return 16'h0777;
            8'h05: return 16'h0003; 8'h06: return 16'h0001; 8'h07: return 16'h313B;
            8'h09: return 16'h073F; 8'h0A: return 16'h000F;
            8'h0C: return 16'h7133; 8'h0D: return 16'h01FF; 8'h0F: return 16'h001B;
            8'h10: return 16'h17F3; 8'h11: return 16'h0777; 8'h12: return 16'h008F;
            8'h13: return 16'h1F00; 8'h20: return 16'h00FF; 8'h21: return 16'h01FF;
            8'h29: return 16'h003F; 8'h2B: return 16'h000F;
            8'h30, 8'h31, 8'h32, 8'h35, 8'h37, 8'h38, 8'h39, 8'h3C: return 16'h0707;
            8'h36, 8'h3D: return 16'h1F0F;
            8'h50, 8'h51: return 16'h00FF;
            8'h52, 8'h53, 8'h6A, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85:
               return 16'h01FF;
            8'h60: return 16'hBF3F; 8'h61: return 16'h0007;
            8'h90: return 16'h031F; 8'h92: return 16'h0700;
            8'h95: return 16'h0300; 8'h97: return 16'h0F00; 8'hA1: return 16'h083F;
            8'hA2: return 16'h0001; 8'hA3: return 16'h0003; 8'hA4: return 16'hF7FF;
            8'hE2: return 16'h9FFF; 8'hE3: return 16'hF0FF;
            8'hE4: return 16'h1F3C; 8'hE5: return 16'h1FC7; 8'hE6: return 16'h0001;
            8'hE7: return 16'h3FFF; 8'hE8: return 16'h003F; 8'hE9: return 16'h000F;
            8'hEB: return 16'hB37F; 8'hEC: return 16'h7FFF;
            8'hED: return 16'h7FFF; 8'hEE: return 16'h0F7F; 8'hEF: return 16'hFB37;
            8'hFE: return 16'h0001; 8'hFF: return 16'h000F;
            default: return 16'hFFFF;
         endcase
      endfunction

      function void home_row(logic [15:0] m);
         row = m[4] ? regs[HStartIdx][7:0] : regs[HEndIdx][7:0];
      endfunction

      function void home_col(logic [15:0] m);
         col = m[5] ? regs[VStartIdx][8:0] : regs[VEndIdx][8:0];
      endfunction

      function void reg_write(logic [7:0] r, logic [15:0] v);
         logic [15:0] m;
         logic        org;
         m = regs[EntryMode];
         org = m[7];
         regs[r] = v & mask_of(r);
         case (r)
            EntryMode: begin
               home_col(regs[r]); home_row(regs[r]);
            end
            HAddrIndex, VAddrIndex: begin
               if (org) begin
                  if (r == HAddrIndex) home_row(m); else home_col(m);
               end else begin
                  col = regs[VAddrIndex][8:0];
                  row = regs[HAddrIndex][7:0];
               end
            end
            HStartIdx: if (org && m[5]) row = regs[HStartIdx][7:0];
            HEndIdx:   if (org && !m[5]) row = regs[HEndIdx][7:0];
            VStartIdx: if (org && m[4]) col = regs[VStartIdx][8:0];
            VEndIdx:   if (org && !m[4]) col = regs[VEndIdx][8:0];
            default: ;
         endcase
      endfunction

      function bit row_step();
         if (regs[EntryMode][4]) begin
            if ({8'd0, row} < regs[HEndIdx]) begin row = row + 8'd1; return 0; end
            row = regs[HStartIdx][7:0];
         end else begin
            if ({8'd0, row} > regs[HStartIdx]) begin row = row - 8'd1; return 0; end
            row = regs[HEndIdx][7:0];
         end
         return 1;
      endfunction

      function bit col_step();
         if (regs[EntryMode][5]) begin
            if ({7'd0, col} < regs[VEndIdx]) begin col = col + 9'd1; return 0; end
            col = regs[VStartIdx][8:0];
         end else begin
            if ({7'd0, col} > regs[VStartIdx]) begin col = col - 9'd1; return 0; end
            col = regs[VEndIdx][8:0];
         end
         return 1;
      endfunction

      function void put_pixel(logic [5:0] red, logic [5:0] green, logic [5:0] blue);
         logic [15:0] m;
         int          r;
         logic [5:0]  s0, s2;
         m = regs[EntryMode];
         r = row;
         if (regs[DriverOut][8]) r = FrameHeight - r - 1;
         if (m[12]) begin s0 = blue; s2 = red; end else begin s0 = red; s2 = blue; end
         if (col < FrameWidth && r >= 0 && r < FrameHeight)
            gram[r * FrameWidth + col] = {s0, green, s2};
         if (m[3]) begin
            if (col_step()) void'(row_step());
         end else begin
            if (row_step()) void'(col_step());
         end
      endfunction

      function logic [23:0] pixel_565();
         logic [17:0] w;
         logic [5:0]  hi, lo;
         logic [23:0] p;
         w = gram[(row % FrameHeight) * FrameWidth + (col % FrameWidth)];
         if (regs[EntryMode][12]) begin hi = w[5:0]; lo = w[17:12]; end
         else begin hi = w[17:12]; lo = w[5:0]; end
         p = {2'b0, hi, 2'b0, w[11:6], 2'b0, lo};
         return ((p & 24'h3e0000) << 2) | ((p & 24'h003f00) << 5) | ((p & 24'h00003e) << 7);
      endfunction

      function void note_transfer(action_type a, logic [7:0] b);
         logic [15:0] v;
         logic [23:0] u;
         case (a)
            ACT_CMD_WR: begin
               index = b; rphase = 1'b0; wphase = '0;
            end
            ACT_CMD_RD: pending_bytes.push_back(8'h00);
            ACT_DAT_WR: begin
               bytes_in = {bytes_in[15:0], b};
               if (index == GramIndex && regs[EntryMode][14]) begin
                  wphase = wphase + 2'd1;
                  if (wphase == 2'd3) begin
                     wphase = '0;
                     if (regs[EntryMode][15]) begin
                        u = bytes_in & 24'hfcfcfc;
                        put_pixel(u[23:18], u[15:10], u[7:2]);
                     end else put_pixel(bytes_in[17:12], bytes_in[11:6], bytes_in[5:0]);
                  end
               end else begin
                  wphase = (wphase == 2'd0) ? 2'd1 : 2'd0;
                  if (wphase == 2'd0) begin
                     v = bytes_in[15:0];
                     if (index == GramIndex)
                        put_pixel({v[15:11], v[15]}, v[10:5], {v[4:0], v[4]});
                     else reg_write(index, v);
                  end
               end
            end
            ACT_DAT_RD: begin
               rphase = ~rphase;
               if (index == GramIndex) begin
                  pending_bytes.push_back(rd_shift[23:16]);
                  if (!rphase) rd_shift = pixel_565();
                  else rd_shift = {rd_shift[15:0], 8'h00};
               end else begin
                  v = (index == IdIndex) ? DeviceId : regs[index];
                  pending_bytes.push_back(rphase ? v[15:8] : v[7:0]);
               end
            end
         endcase
      endfunction

      function void check_byte(logic [7:0] got);
         logic [7:0] want;
         reads_seen++;
         if (pending_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected read byte, expected none, actual %02h", $time, got);
            return;
         end
         want = pending_bytes.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: read_byte expected %02h actual %02h", $time, want, got);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_action = ACT_CMD_WR;
   logic [7:0] req_data_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_byte;

   lcd_bus_gram_window_writer_top dut (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_data_byte,
      .rsp_valid, .rsp_stall, .rsp_read_byte
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lcd_scoreboard board;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_off = 0;
   int  sent = 0;
   longint cycles = 0;
   localparam longint CycleLimit = 3_000_000;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) board.check_byte(rsp_read_byte);

   // receiver stall, with an optional long hold-off counted here
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // valid stays up after a transfer; the next call or drain decides what follows
   task automatic send(action_type a, logic [7:0] b);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= a;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_transfer(a, b);
      sent++;
      @(negedge clock);
   endtask

   task automatic reg16(logic [7:0] r, logic [15:0] v);
      send(ACT_CMD_WR, r);
      send(ACT_DAT_WR, v[15:8]);
      send(ACT_DAT_WR, v[7:0]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   // small window, mostly inside the frame, random scan direction and format
   task automatic window_burst(int pixels);
      logic [7:0] r0, r1;
      logic [8:0] c0, c1;
      logic [15:0] m;
      r0 = 8'($urandom_range(0, 255)); r1 = r0 + 8'($urandom_range(0, 5));
      if (r1 < r0) r1 = 8'hff;
      c0 = 9'($urandom_range(0, 511)); c1 = c0 + 9'($urandom_range(0, 5));
      if (c1 < c0) c1 = 9'h1ff;
      if ($urandom_range(3) != 0) begin
         r0 = 8'($urandom_range(0, 235)); r1 = r0 + 8'($urandom_range(0, 4));
         c0 = 9'($urandom_range(0, 315)); c1 = c0 + 9'($urandom_range(0, 4));
      end
      reg16(HStartIdx, {8'h00, r0});
      reg16(HEndIdx, {8'h00, r1});
      reg16(VStartIdx, {7'h00, c0});
      reg16(VEndIdx, {7'h00, c1});
      reg16(DriverOut, $urandom_range(1) ? 16'h0100 : 16'h0000);
      m = 16'($urandom);
      reg16(EntryMode, m);
      if ($urandom_range(1)) begin
         reg16(HAddrIndex, 16'($urandom_range(0, 255)));
         reg16(VAddrIndex, 16'($urandom_range(0, 511)));
      end
      send(ACT_CMD_WR, GramIndex);
      repeat (pixels) begin
         repeat (m[14] ? 3 : 2) send(ACT_DAT_WR, 8'($urandom));
         if ($urandom_range(4) == 0) send(ACT_DAT_RD, 8'($urandom));
      end
      reg16(EntryMode, m);
      send(ACT_CMD_WR, GramIndex);
      repeat ($urandom_range(2, 10)) send(ACT_DAT_RD, 8'($urandom));
   endtask

   task automatic random_item();
      action_type a;
      a = action_type'($urandom_range(3));
      if ($urandom_range(3) == 0) a = ACT_CMD_WR;
      send(a, $urandom_range(1) ? 8'($urandom) : GramIndex);
   endtask

   initial begin
      board = new();
      board.clear();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: device id, command read, extremes, both pixel formats
      send(ACT_CMD_WR, IdIndex);
      send(ACT_DAT_RD, 8'h00);
      send(ACT_DAT_RD, 8'hff);
      send(ACT_CMD_RD, 8'hff);
      reg16(8'hff, 16'hffff);
      send(ACT_DAT_RD, 8'h00);
      send(ACT_DAT_RD, 8'h00);
      send(ACT_CMD_WR, GramIndex);
      send(ACT_DAT_WR, 8'hff);
      send(ACT_DAT_WR, 8'h00);
      send(ACT_DAT_RD, 8'h00);
      send(ACT_DAT_RD, 8'h00);
      send(ACT_DAT_RD, 8'h00);
      reg16(EntryMode, 16'hffff);
      send(ACT_CMD_WR, GramIndex);
      repeat (3) send(ACT_DAT_WR, 8'hff);
      // mode change with a byte left over
      send(ACT_DAT_WR, 8'h5a);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 85 : 0;
         recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 12 : 0;
         if (ph == 2) hold_off = 300;
         for (int k = sent; sent < k + 700;) begin
            if ($urandom_range(9) < 7) window_burst($urandom_range(1, 12));
            else repeat (10) random_item();
         end
         drain();
      end

      $display("%0d transfers sent, %0d read bytes checked over windows, formats and flips",
               sent, board.reads_seen);
      if (board.errors == 0 && board.pending_bytes.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/lbgw_pkg.sv
sv/lbgw_ram.sv
sv/lbgw_ctrl.sv
sv/lbgw_dp.sv
sv/lcd_bus_gram_window_writer_top.sv
tb/lcd_bus_gram_window_writer_top_tb.sv
